>>> design/smt_pkg.sv
// smt_pkg: shared sizes, action codes and the structs that run between the
// table cells and the control logic of set_membership_table_unit
// no dependencies
`timescale 1ns / 1ps

package smt_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // port field widths
  localparam int ACT_W     = 2;
  localparam int KEY_IN_W  = 32;
  localparam int COUNT_W   = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMT
  } state_t;

  // search token walking down the cell chain
  typedef struct packed {
    logic                 vld;
    logic [KEY_WIDTH-1:0] key;
    logic                 found;
    logic [IDX_W-1:0]     hit_idx;
    logic                 free_ok;
    logic [IDX_W-1:0]     free_idx;
  } probe_t;

  // update broadcast to all cells at the end of a search
  typedef struct packed {
    logic                 set;
    logic                 clr;
    logic [IDX_W-1:0]     idx;
    logic [KEY_WIDTH-1:0] key;
  } commit_t;

endpackage

>>> design/smt_cell.sv
// smt_cell: one slot of the set table, holds a key and its valid mark,
// checks the passing search token and hands it on to the next cell
// depends on smt_pkg
`timescale 1ns / 1ps

module smt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [smt_pkg::IDX_W-1:0] cell_idx,
  input  smt_pkg::probe_t           probe_i,
  output smt_pkg::probe_t           probe_o,
  input  smt_pkg::commit_t          cmt_i,
  output logic                      slot_vld_o
);
  import smt_pkg::*;

  logic [KEY_WIDTH-1:0] slot_key_r;
  logic                 slot_vld_r;
  probe_t               probe_r;
  probe_t               probe_nxt;
  logic                 match;
  logic                 sel;

  assign match = slot_vld_r && (slot_key_r == probe_i.key);
  assign sel   = (cmt_i.idx == cell_idx);

  always_comb begin
    probe_nxt = probe_i;
    if (probe_i.vld) begin
      // first hit and first free slot win, lower cells come first
      if (match && !probe_i.found) begin
        probe_nxt.found   = 1'b1;
        probe_nxt.hit_idx = cell_idx;
      end
      if (!slot_vld_r && !probe_i.free_ok) begin
        probe_nxt.free_ok  = 1'b1;
        probe_nxt.free_idx = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_r.key      <= probe_nxt.key;
    probe_r.found    <= probe_nxt.found;
    probe_r.hit_idx  <= probe_nxt.hit_idx;
    probe_r.free_ok  <= probe_nxt.free_ok;
    probe_r.free_idx <= probe_nxt.free_idx;
    if (cmt_i.set && sel) begin
      slot_key_r <= cmt_i.key;
    end
    if (!rst_n) begin
      slot_vld_r  <= 1'b0;
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_nxt.vld;
      if (cmt_i.set && sel) begin
        slot_vld_r <= 1'b1;
      end else if (cmt_i.clr && sel) begin
        slot_vld_r <= 1'b0;
      end
    end
  end

  assign probe_o    = probe_r;
  assign slot_vld_o = slot_vld_r;

endmodule

>>> design/set_membership_table_unit.sv
// set_membership_table_unit: bounded key set with lookup, insert and delete
// built as a chain of smt_cell slots plus a small controller
// depends on smt_pkg and smt_cell
//
// usage:
//   in channel: one transaction per action; in_tdata holds action (2 bits,
//   0 lookup, 1 insert if absent, 2 delete if present, 3 acts as lookup)
//   and the key (32 bits)
//   out channel: one transaction per action with found, full_reject and
//   the element count after the action
//   out_tvalid rises once the token has passed every cell: the accepting edge
//   loads the first cell and the token steps on one cell at a time, then
//   fin_r latches the token and the ST_CMT step applies the update and
//   loads the result register
//   one action is in flight at a time, so a new action is taken only after
//   the previous one has applied its update and loaded its result
//   the result sits in an output register; a new action is accepted while
//   it waits, and a stalled receiver only holds back the update step
//   reset (rst_n low, synchronous) empties the set and clears the count;
//   no clearing pass is needed
`timescale 1ns / 1ps

module set_membership_table_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] action, [33:2] key, [39:34] zero
  input  logic [smt_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] found, [1] full_reject, [6:2] count, [7] zero
  output logic [smt_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import smt_pkg::*;

  state_t               state_r;
  state_t               state_nxt;
  logic [ACT_W-1:0]     act_r;
  probe_t               fin_r;
  logic [CNT_W-1:0]     held_cnt_r;
  logic [CNT_W-1:0]     held_cnt_nxt;
  logic                 out_vld_r;
  logic                 out_vld_nxt;
  logic                 out_found_r;
  logic                 out_found_nxt;
  logic                 out_rej_r;
  logic                 out_rej_nxt;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic [COUNT_W-1:0]   out_cnt_nxt;
  logic                 in_acc;
  logic                 rej;
  logic [63:0]          key_ext;
  logic [63:0]          cnt_ext;
  commit_t              cmt;
  probe_t               prb [CAPACITY+1];
  logic [CAPACITY-1:0]  slot_vld;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign key_ext   = 64'(in_tdata[ACT_W +: KEY_IN_W]);

  // token entering the chain
  always_comb begin
    prb[0]          = '0;
    prb[0].vld      = in_acc;
    prb[0].key      = key_ext[KEY_WIDTH-1:0];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    smt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(i)),
      .probe_i    (prb[i]),
      .probe_o    (prb[i+1]),
      .cmt_i      (cmt),
      .slot_vld_o (slot_vld[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      held_cnt_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_cnt_r <= held_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tdata[ACT_W-1:0];
    end
    if (prb[CAPACITY].vld) begin
      fin_r <= prb[CAPACITY];
    end
    out_found_r <= out_found_nxt;
    out_rej_r   <= out_rej_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign cnt_ext = 64'(held_cnt_nxt);

  always_comb begin
    state_nxt     = state_r;
    held_cnt_nxt  = held_cnt_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_found_nxt = out_found_r;
    out_rej_nxt   = out_rej_r;
    out_cnt_nxt   = out_cnt_r;
    rej           = 1'b0;
    cmt           = '0;
    cmt.key       = fin_r.key;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (prb[CAPACITY].vld) begin
          state_nxt = ST_CMT;
        end
      end
      ST_CMT: begin
        // update only once the output register can take the result
        if (!out_vld_r || out_tready) begin
          case (act_r)
            ACT_INSERT: begin
              if (!fin_r.found) begin
                if (fin_r.free_ok) begin
                  cmt.set      = 1'b1;
                  cmt.idx      = fin_r.free_idx;
                  held_cnt_nxt = held_cnt_r + CNT_W'(1);
                end else begin
                  rej = 1'b1;
                end
              end
            end
            ACT_DELETE: begin
              if (fin_r.found) begin
                cmt.clr = 1'b1;
                cmt.idx = fin_r.hit_idx;
                if (held_cnt_r != '0) begin
                  held_cnt_nxt = held_cnt_r - CNT_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
          out_vld_nxt   = 1'b1;
          out_found_nxt = fin_r.found;
          out_rej_nxt   = rej;
          out_cnt_nxt   = cnt_ext[COUNT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_rej_r, out_found_r};

  // count tracks the valid marks held in the cells
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_vld) == 32'(held_cnt_r))
    else $error("held count differs from occupied slots");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_cnt_r) <= CAPACITY)
    else $error("held count above capacity");

  a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    prb[CAPACITY].vld |-> state_r == ST_SRCH)
    else $error("search token left the chain outside a search");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmt.set |=> held_cnt_r == $past(held_cnt_r) + CNT_W'(1))
    else $error("insert did not bump the count");

  a_reject_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("reject reported for a present key");

endmodule
